// ===== rtl/core/spn_block_chained_hash_macros.svh =====
// ----------------------------------------------------------------------------
// spn_block_chained_hash assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SPN_BLOCK_CHAINED_HASH_MACROS_SVH
`define SPN_BLOCK_CHAINED_HASH_MACROS_SVH

`ifndef SYNTH
// check with reset masking
`define SPNH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spnh assertion failed");
// check that also holds during reset
`define SPNH_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("spnh assertion failed");
`else
`define SPNH_ASSERT(lbl, clk, rst, prop)
`define SPNH_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/spnh_pkg.sv =====
// ----------------------------------------------------------------------------
// spnh_pkg
// Types, constants and cipher helper functions for the chained SPN hash.
// ----------------------------------------------------------------------------
`default_nettype none

package spnh_pkg;

   localparam int unsigned BLOCK_W   = 16;
   localparam int unsigned NIBBLES   = 4;
   localparam int unsigned ROUNDS    = 4;
   localparam int unsigned FINAL_ROT = 4;

   typedef logic [BLOCK_W-1:0] block_type;

   localparam logic [3:0] SBOX [16] = '{
      4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
      4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
   };

   // new bit j takes old bit SRC_BIT[j]
   localparam logic [3:0] SRC_BIT [16] = '{
      4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
   };

   // staged input word
   typedef struct packed {
      logic      valid;
      block_type message_block;
      logic      end_of_message;
   } stage_word_type;

   function automatic block_type rotr(input block_type v, input int unsigned r);
      block_type o;
      o = (v >> r) | (v << (BLOCK_W - r));
      return o;
   endfunction

   function automatic block_type substitute(input block_type v);
      block_type o;
      for (int n = 0; n < NIBBLES; n++) begin
         o[4*n +: 4] = SBOX[v[4*n +: 4]];
      end
      return o;
   endfunction

   function automatic block_type transpose(input block_type v);
      block_type o;
      for (int j = 0; j < BLOCK_W; j++) begin
         o[j] = v[SRC_BIT[j]];
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spnh_req_if.sv =====
// ----------------------------------------------------------------------------
// spnh_req_if
// Block input channel: valid/ready with message word payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spnh_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] message_block;
   logic        end_of_message;

   modport source (output valid, output message_block, output end_of_message, input ready);
   modport sink   (input valid, input message_block, input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spnh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spnh_rsp_if
// Digest output channel: valid/ready with digest payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface spnh_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] digest;

   modport source (output valid, output digest, input ready);
   modport sink   (input valid, input digest, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spnh_in_stage.sv =====
// ----------------------------------------------------------------------------
// spnh_in_stage
// Input register for message words; holds while the stage cannot advance.
// ----------------------------------------------------------------------------
`default_nettype none

module spnh_in_stage
   import spnh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   spnh_req_if.sink       req_ch,
   input  logic           advance,
   output stage_word_type stage
);

   stage_word_type stage_ff;
   stage_word_type stage_in;

   assign req_ch.ready = !stage_ff.valid || advance;

   always_comb begin
      stage_in = stage_ff;
      if (req_ch.ready) begin
         stage_in.valid          = req_ch.valid;
         stage_in.message_block  = req_ch.message_block;
         stage_in.end_of_message = req_ch.end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.message_block  <= stage_in.message_block;
      stage_ff.end_of_message <= stage_in.end_of_message;
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spnh_cipher.sv =====
// ----------------------------------------------------------------------------
// spnh_cipher
// Four-round toy SPN keyed by the message word, with the key word fed forward.
// ----------------------------------------------------------------------------
`default_nettype none

module spnh_cipher
   import spnh_pkg::*;
(
   input  block_type chain_value,
   input  block_type message_block,
   output block_type next_chain
);

   block_type state;

   always_comb begin
      state = chain_value;
      for (int unsigned r = 0; r < ROUNDS; r++) begin
         state = substitute(state ^ rotr(message_block, r));
         if (r + 1 < ROUNDS) begin
            state = transpose(state);
         end else begin
            state = state ^ rotr(message_block, FINAL_ROT);
         end
      end
   end

   // feed-forward of the key word
   assign next_chain = state ^ message_block;

endmodule

`default_nettype wire

// ===== rtl/core/spnh_out_stage.sv =====
// ----------------------------------------------------------------------------
// spnh_out_stage
// Digest output register; reports when it can take a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module spnh_out_stage
   import spnh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  block_type digest_in,
   output logic      free,
   spnh_rsp_if.source rsp_ch
);

   logic      valid_ff;
   logic      valid_in;
   block_type digest_ff;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digest_ff <= digest_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_ch.valid  = valid_ff;
   assign rsp_ch.digest = digest_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spn_block_chained_hash.sv =====
// ----------------------------------------------------------------------------
// spn_block_chained_hash
// Chained 16-bit hash over message words using a four-round toy SPN cipher.
// ----------------------------------------------------------------------------
// Each accepted word is the key of a small SPN cipher that encrypts the
// running chain value; the word is XORed back onto the cipher output to form
// the new chain value. A word flagged end_of_message produces one digest word
// on rsp_ch and the chain returns to initial_value; other words produce
// nothing. Throughput is one word per clock: a word sits in the input
// register while the whole cipher is evaluated from it, and the result is
// registered into the chain register (and the digest register for a last
// word), so the next word can follow right behind. A digest passes through
// the input register and then the digest register. The only stall source
// is a full digest register: a last word waits in the input register until
// the digest ahead of it is taken. Writing csr_wr_data (csr_wr_en high) sets
// initial_value and reloads the chain at once; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spn_block_chained_hash_macros.svh"

module spn_block_chained_hash
   import spnh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spnh_req_if.sink    req_ch,
   spnh_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   stage_word_type stage;
   logic           advance;
   logic           out_free;
   logic           step;
   logic           emit;

   block_type initial_ff;
   block_type chain_ff;
   block_type chain_in;
   block_type cipher_out;

   // input register
   spnh_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   // one full cipher pass per cycle
   spnh_cipher u_cipher (
      .chain_value   (chain_ff),
      .message_block (stage.message_block),
      .next_chain    (cipher_out)
   );

   // a non-last word never needs the digest register
   assign advance = !stage.end_of_message || out_free;
   assign step    = stage.valid && advance;
   assign emit    = step && stage.end_of_message;

   always_comb begin
      priority if (csr_wr_en) begin
         chain_in = csr_wr_data;
      end else if (step) begin
         chain_in = stage.end_of_message ? initial_ff : cipher_out;
      end else begin
         chain_in = chain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_ff <= '0;
         chain_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            initial_ff <= csr_wr_data;
         end
         chain_ff <= chain_in;
      end
   end

   // digest register
   spnh_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .digest_in (cipher_out),
      .free      (out_free),
      .rsp_ch    (rsp_ch)
   );

   // a last word that moves shows up as the digest next cycle
   `SPNH_ASSERT(a_emit_digest, clock, reset, emit |=> (rsp_ch.valid && (rsp_ch.digest == $past(cipher_out))))
   // chain follows the cipher for a mid-message word
   `SPNH_ASSERT(a_chain_step, clock, reset, (step && !stage.end_of_message && !csr_wr_en) |=> (chain_ff == $past(cipher_out)))
   // chain restarts from initial value after a digest
   `SPNH_ASSERT(a_chain_restart, clock, reset, (emit && !csr_wr_en) |=> (chain_ff == initial_ff))
   // the input register only holds back while the digest register is blocked
   `SPNH_ASSERT(a_stall_cause, clock, reset, (stage.valid && !advance) |-> (rsp_ch.valid && !rsp_ch.ready))
   // a csr write lands in both registers
   `SPNH_ASSERT(a_csr_load, clock, reset, csr_wr_en |=> ((chain_ff == $past(csr_wr_data)) && (initial_ff == $past(csr_wr_data))))

endmodule

`default_nettype wire

// ===== test/spn_block_chained_hash_check.sv =====
// ----------------------------------------------------------------------------
// spn_block_chained_hash_check
// Watches the word and digest channels of the chained SPN hash, predicts
// every digest from the accepted words and compares it with what comes out.
// ----------------------------------------------------------------------------

module spn_block_chained_hash_check
   import spnh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spnh_req_if         req_ch,
   spnh_rsp_if         rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          digests_owed,
   output int          words_seen,
   output int          digests_seen
);

   localparam logic [3:0] NIBBLE_SUB [16] = '{
      4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
      4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
   };

   // output bit j is taken from input bit BIT_FROM[j]
   localparam logic [3:0] BIT_FROM [16] = '{
      4'd0, 4'd4, 4'd8,  4'd12, 4'd1, 4'd5, 4'd9,  4'd13,
      4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
   };

   localparam int MAX_REPORTS = 10;

   block_type start_value;
   block_type chain_value;
   block_type digests_due [$];
   int        errors;
   int        words;
   int        digests;

   function automatic block_type rot_right(input block_type v, input int unsigned r);
      logic [31:0] twice;
      twice = {v, v};
      return twice[r +: 16];
   endfunction

   function automatic block_type sub_nibbles(input block_type v);
      block_type o;
      for (int n = 0; n < 4; n++) begin
         o[4*n +: 4] = NIBBLE_SUB[v[4*n +: 4]];
      end
      return o;
   endfunction

   function automatic block_type permute_bits(input block_type v);
      block_type o;
      for (int j = 0; j < 16; j++) begin
         o[j] = v[BIT_FROM[j]];
      end
      return o;
   endfunction

   // Chain step where the word keys the cipher over the chain, then is
   // folded back onto the cipher output
   function automatic block_type chain_step(input block_type chain, input block_type word);
      block_type s;
      s = chain;
      for (int r = 0; r < 4; r++) begin
         s = sub_nibbles(s ^ rot_right(word, r));
         if (r < 3) begin
            s = permute_bits(s);
         end else begin
            s = s ^ rot_right(word, 4);
         end
      end
      return s ^ word;
   endfunction

   function automatic void note_failure(input string what);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("[%0t] check: %s", $realtime, what);
      end
   endfunction

   always @(posedge clock) begin : watch
      block_type want;
      if (reset) begin
         start_value = '0;
         chain_value = '0;
         digests_due.delete();
         errors = 0;
         words = 0;
         digests = 0;
      end else begin
         // writes happen only while idle, so ordering against words is moot
         if (csr_wr_en) begin
            start_value = csr_wr_data;
            chain_value = csr_wr_data;
         end
         if (req_ch.valid && req_ch.ready) begin
            words++;
            chain_value = chain_step(chain_value, req_ch.message_block);
            if (req_ch.end_of_message) begin
               digests_due.push_back(chain_value);
               chain_value = start_value;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            digests++;
            if (digests_due.size() == 0) begin
               note_failure($sformatf("digest %h arrived with none pending", rsp_ch.digest));
            end else begin
               want = digests_due.pop_front();
               if (rsp_ch.digest !== want) begin
                  note_failure($sformatf("digest mismatch: expected %h, got %h",
                                         want, rsp_ch.digest));
               end
            end
         end
      end
      fail_count   <= errors;
      digests_owed <= digests_due.size();
      words_seen   <= words;
      digests_seen <= digests;
   end

endmodule

// ===== test/spn_block_chained_hash_test.sv =====
// ----------------------------------------------------------------------------
// spn_block_chained_hash_test
// Drives message words and initial-value writes into the chained SPN hash
// under three sender/receiver stall mixes; the checker beside the block
// predicts each digest and counts failures, and this module gives the verdict.
// ----------------------------------------------------------------------------

module spn_block_chained_hash_test;
   import spnh_pkg::*;

   localparam int PHASE_WORDS = 300;
   localparam int DRAIN_WAIT  = 6;    // margin for the block to settle before a write
   localparam int RUN_LIMIT   = 2_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   int send_idle_pct;
   int recv_idle_pct;
   int csr_writes;
   int fail_count;
   int digests_owed;
   int words_seen;
   int digests_seen;

   spnh_req_if req_ch ();
   spnh_rsp_if rsp_ch ();

   spn_block_chained_hash u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   spn_block_chained_hash_check u_check (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .digests_owed (digests_owed),
      .words_seen   (words_seen),
      .digests_seen (digests_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // digest receiver: drops ready at random per the current stall mix
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // One word onto the input channel. Idle cycles go in front, so a word that
   // follows straight on keeps valid high with a single assignment.
   task automatic send_word(input block_type word, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.message_block  <= word;
      req_ch.end_of_message <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Setting the initial value needs a quiet block: every digest taken, then
   // a wait so a trailing non-last word has reached the chain register.
   // A partial message left in the chain is abandoned by the write.
   task automatic write_initial(input block_type value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (digests_owed != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   initial begin : stimulus
      int        sent;
      int        len;
      bit        mid_done;
      block_type word;

      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.message_block  = '0;
      req_ch.end_of_message = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      send_idle_pct         = 20;
      recv_idle_pct         = 46;
      csr_writes            = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: single-word messages at the field extremes, chain from reset
      send_word(16'h0000, 1'b1);
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0001, 1'b1);
      send_word(16'h8000, 1'b1);
      // multi-word messages, incl. repeated all-ones words
      send_word(16'h1234, 1'b0);
      send_word(16'h5678, 1'b0);
      send_word(16'h9ABC, 1'b1);
      send_word(16'hFFFF, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b1);
      // all-ones initial value
      write_initial(16'hFFFF);
      send_word(16'h0000, 1'b1);
      send_word(16'hFFFF, 1'b1);
      send_word(16'hA5A5, 1'b0);
      send_word(16'h5A5A, 1'b1);
      // message left half done; the write must restart the chain
      send_word(16'h0F0F, 1'b0);
      send_word(16'hF0F0, 1'b0);
      write_initial(16'h0000);
      send_word(16'h3C3C, 1'b1);
      write_initial(16'h8001);
      send_word(16'h7FFE, 1'b1);

      // random: three stall mixes, each opened with a fresh initial value
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 46;
               write_initial(block_type'($urandom));
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 20;
               write_initial(16'hFFFF);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_initial(16'h0000);
            end
         endcase
         sent     = 0;
         mid_done = 1'b0;
         while (sent < PHASE_WORDS) begin
            // mostly short messages, now and then a long one
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(15))
                  0:       word = 16'h0000;
                  1:       word = 16'hFFFF;
                  default: word = block_type'($urandom);
               endcase
               send_word(word, k == len - 1);
               sent++;
            end
            // halfway: abandon a partial message with a new initial value
            if (!mid_done && sent >= PHASE_WORDS / 2) begin
               mid_done = 1'b1;
               len = $urandom_range(1, 3);
               for (int k = 0; k < len; k++) begin
                  send_word(block_type'($urandom), 1'b0);
                  sent++;
               end
               write_initial(block_type'($urandom));
            end
         end
      end

      // drain
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (digests_owed != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Covered %0d words and %0d digests across %0d initial-value writes",
               words_seen, digests_seen, csr_writes);
      $display("under three stall mixes, with abandoned messages; %0d failures",
               fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #RUN_LIMIT;
      $display("Run limit reached with %0d digests owed", digests_owed);
      $display("TEST FAILED");
      $finish;
   end

endmodule
